@@ hw/rtl/sha256_pkg.sv @@
// Package with shared types, constants and round functions for the SHA-256 hasher.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // Front-to-back queue entry: one block of sixteen words and its kind.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_FILL,
    FR_PAD,
    FR_ZERO,
    FR_LEN
  } fr_state_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

@@ hw/rtl/sha256_front.sv @@
// Front end: gathers bytes into blocks, appends padding and length, hands blocks on.
module sha256_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              message_byte,
  input  logic                    byte_present,
  input  logic                    end_of_message,
  output logic                    blk_valid,
  input  logic                    blk_ready,
  output sha256_pkg::blk_entry_t  blk_data
);
  import sha256_pkg::*;

  // Bytes shift in at the low end, so the first byte of a block ends up on top.
  logic [511:0] blk_q;
  logic [6:0]   fill;
  logic [63:0]  message_bits;
  logic [63:0]  total;
  fr_state_t    state;
  logic         out_full;
  blk_entry_t   out_q;
  logic         fill_last;
  logic         take;

  assign blk_valid = out_full;
  assign blk_data  = out_q;
  assign fill_last = (fill == 7'd63);
  // Bytes are taken in FILL; the byte that completes a block needs the slot free.
  assign in_ready  = (state == FR_FILL) && !(out_full && fill_last);
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      message_bits <= '0;
      state        <= FR_FILL;
      out_full     <= 1'b0;
      total        <= '0;
    end else begin
      if (out_full && blk_ready) out_full <= 1'b0;
      case (state)
        FR_FILL: begin
          if (take) begin
            if (byte_present) begin
              blk_q <= {blk_q[503:0], message_byte};
              if (fill_last) begin
                out_q.block     <= {blk_q[503:0], message_byte};
                out_q.final_blk <= 1'b0;
                out_full        <= 1'b1;
                message_bits    <= message_bits + 64'd512;
                fill            <= '0;
              end else begin
                fill <= fill + 7'd1;
              end
            end
            if (end_of_message) state <= FR_PAD;
          end
        end
        FR_PAD: begin
          total <= message_bits + {54'd0, fill, 3'd0};
          blk_q <= {blk_q[503:0], 8'h80};
          fill  <= fill + 7'd1;
          state <= (fill == 7'd55) ? FR_LEN : FR_ZERO;
        end
        FR_ZERO: begin
          // A full block here means the padding spilled past the length field.
          if (fill == 7'd64) begin
            if (!out_full) begin
              out_q.block     <= blk_q;
              out_q.final_blk <= 1'b0;
              out_full        <= 1'b1;
              fill            <= '0;
            end
          end else begin
            blk_q <= {blk_q[503:0], 8'h00};
            fill  <= fill + 7'd1;
            if (fill == 7'd55) state <= FR_LEN;
          end
        end
        FR_LEN: begin
          if (!out_full) begin
            out_q.block     <= {blk_q[447:0], total};
            out_q.final_blk <= 1'b1;
            out_full        <= 1'b1;
            fill            <= '0;
            message_bits    <= '0;
            state           <= FR_FILL;
          end
        end
        default: state <= FR_FILL;
      endcase
    end
  end

endmodule

@@ hw/rtl/sha256_back.sv @@
// Back end: 64-round compression engine with message schedule and digest output.
module sha256_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    blk_valid,
  output logic                    blk_ready,
  input  sha256_pkg::blk_entry_t  blk_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word
);
  import sha256_pkg::*;

  bk_state_t state, state_next;
  word_t     h [8];
  word_t     v [8];
  word_t     w [16];
  logic [5:0] rnd;
  logic [2:0] idx;
  logic       final_q;
  word_t      t1, t2, wnew;

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    wnew = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (blk_valid) state_next = BK_ROUND;
      BK_ROUND: if (rnd == 6'd63) state_next = BK_ADD;
      BK_ADD:   state_next = final_q ? BK_EMIT : BK_IDLE;
      BK_EMIT:  if (out_ready && idx == 3'd7) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign blk_ready   = (state == BK_IDLE);
  assign out_valid   = (state == BK_EMIT);
  assign digest_word = h[idx];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rnd   <= '0;
      idx   <= '0;
      for (int i = 0; i < 8; i++) h[i] <= InitHash[i];
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: begin
          if (blk_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= blk_data.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            final_q <= blk_data.final_blk;
            rnd <= '0;
          end
        end
        BK_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
        end
        BK_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          idx <= '0;
        end
        BK_EMIT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= InitHash[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sha256_message_hasher.sv @@
// Top level of the SHA-256 byte-stream hasher.
// Throughput: one byte per cycle while a block fills, but the byte that completes a block
// waits while the held slot is full; the round engine takes one 64-byte block at a time, when
// idle. Padding shifts in one byte per cycle with the input held off, pausing while a
// spilled block waits for the slot; it spills when the last block holds 56..63 bytes.
// Reset (rst, synchronous) restores the initial chaining words and clears counts.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // message_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast    // last_word
);
  import sha256_pkg::*;

  // The front end holds one finished block so it can keep filling while the
  // round engine works on the previous one.
  logic       blk_valid, blk_ready;
  blk_entry_t blk_data;
  logic [31:0] dw;
  logic [2:0]  wi;

  sha256_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .message_byte(s_tdata), .byte_present(s_tuser), .end_of_message(s_tlast),
    .blk_valid, .blk_ready, .blk_data
  );

  sha256_back u_back (
    .clk, .rst,
    .blk_valid, .blk_ready, .blk_data,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .digest_word(dw), .word_index(wi), .last_word(m_tlast)
  );

  assign m_tdata = {5'd0, wi, dw};

endmodule
